>>> src/mandelbrot_escape_iterator_core_assert.svh
// Assertion helpers for the RTL files of the escape iterator core.
`ifndef MANDELBROT_ESCAPE_ITERATOR_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the condition.
`define MEI_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the condition.
`define MEI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> src/mei_pkg.sv
package mei_pkg;

   localparam int FRAC_BITS_DEF = 44;
   localparam int IMAGE_DIM     = 4096;

   localparam int COL_W       = 12;
   localparam int ORIGIN_W    = 48;
   localparam int STEP_W      = 47;
   localparam int ITER_W      = 16;
   localparam int MAG_OUT_W   = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 48;

   // Signed workspace for saturating sums, rounded product magnitude width
   // (holds the cap of 2^62) and width of the squared magnitude sum.
   localparam int SAT_W  = 66;
   localparam int RMAG_W = 63;
   localparam int SUM_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_REAL   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_IMAG   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_STEP    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITERATION = 8'd3;

   typedef struct packed {
      logic signed [ORIGIN_W-1:0] origin_real;
      logic signed [ORIGIN_W-1:0] origin_imag;
      logic [STEP_W-1:0]          pixel_step;
      logic [ITER_W-1:0]          max_iterations;
   } mei_cfg_type;

   localparam mei_cfg_type CFG_RESET = '{
      origin_real:    -48'sd74766790688768,
      origin_imag:    -48'sd28037546508288,
      pixel_step:     47'd15032385536,
      max_iterations: 16'd255
   };

   typedef struct packed {
      logic       load_pixel;
      logic       form_c;
      logic       take_abs;
      logic       mul_en;
      logic [1:0] mul_phase;
      logic       acc_clear;
      logic       acc_add;
      logic       round;
      logic       advance;
      logic       load_result;
   } mei_cmd_type;

   typedef struct packed {
      logic finished;
   } mei_status_type;

endpackage

>>> src/mei_csr.sv
module mei_csr import mei_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output mei_cfg_type            cfg
);

   mei_cfg_type cfg_ff;
   mei_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_REAL:   cfg_in.origin_real    = csr_data[ORIGIN_W-1:0];
            CSR_ORIGIN_IMAG:   cfg_in.origin_imag    = csr_data[ORIGIN_W-1:0];
            CSR_PIXEL_STEP:    cfg_in.pixel_step     = csr_data[STEP_W-1:0];
            CSR_MAX_ITERATION: cfg_in.max_iterations = csr_data[ITER_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/mei_ctrl.sv
`include "mandelbrot_escape_iterator_core_assert.svh"

module mei_ctrl import mei_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  mei_status_type status,
   output mei_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FORM_C = 3'd1;
   localparam logic [2:0] ST_ABS    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_ROUND  = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   // Four partial products are issued, the last one is accumulated in the phase after it.
   localparam logic [2:0] MUL_LAST = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic [2:0] phase_ff;
   logic [2:0] phase_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = ST_FORM_C;
            end
         end
         ST_FORM_C: begin
            cmd.form_c = 1'b1;
            state_in   = ST_ABS;
         end
         ST_ABS: begin
            cmd.take_abs = 1'b1;
            phase_in     = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_phase = phase_ff[1:0];
            cmd.mul_en    = (phase_ff != MUL_LAST);
            cmd.acc_clear = (phase_ff == '0);
            cmd.acc_add   = (phase_ff != '0);
            if (phase_ff == MUL_LAST) begin
               state_in = ST_ROUND;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.finished) begin
               // A result still waiting for its transfer holds the core here.
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.load_result = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_ABS;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MEI_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.load_result,
      !rsp_valid_ff || rsp_ready, "result loaded while the previous one awaits its transfer")
   `MEI_ASSERT_SAME(a_phase_range, clock, reset, state_ff == ST_MUL,
      phase_ff <= MUL_LAST, "multiply phase out of range")
   `MEI_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready,
      state_ff == ST_FORM_C && !req_ready, "accepted pixel did not start")
   `MEI_ASSERT_NEXT(a_result_shown, clock, reset, cmd.load_result,
      rsp_valid_ff && state_ff == ST_IDLE, "loaded result not presented")

endmodule

>>> src/mei_dp.sv
module mei_dp import mei_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic [COL_W-1:0]     req_pixel_col,
   input  logic [COL_W-1:0]     req_pixel_row,
   input  mei_cfg_type          cfg,
   input  mei_cmd_type          cmd,
   output mei_status_type       status,
   output logic [ITER_W-1:0]    rsp_escape_count,
   output logic [MAG_OUT_W-1:0] rsp_exit_magnitude
);

   localparam int QW      = FRAC_BITS + 8;
   localparam int M       = FRAC_BITS + 9;
   localparam int HW      = M - 32;
   localparam int OPW     = (HW > 32) ? HW : 32;
   localparam int ACC_W   = 2 * M;
   localparam int RND_W   = ACC_W + 1 - FRAC_BITS;
   localparam int CMP_W   = (RND_W > RMAG_W) ? RND_W : RMAG_W;
   localparam int PROD_W  = COL_W + STEP_W;
   localparam int Q24_SHR = FRAC_BITS - 24;

   localparam logic signed [SAT_W-1:0] Q_MAX =
      $signed((SAT_W'(1) << (FRAC_BITS + 7)) - SAT_W'(1));
   localparam logic signed [SAT_W-1:0] Q_MIN = -Q_MAX - SAT_W'(1);
   localparam logic [ACC_W:0]   HALF    = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic [CMP_W-1:0] MAG_CAP = CMP_W'(1) << (RMAG_W - 1);
   localparam logic [SUM_W-1:0] FOUR    = SUM_W'(4) << FRAC_BITS;

   function automatic logic [COL_W-1:0] clamp_index(input logic [COL_W-1:0] idx);
      if (32'(idx) > IMAGE_DIM - 1) begin
         return COL_W'(IMAGE_DIM - 1);
      end
      return idx;
   endfunction

   function automatic logic signed [QW-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      if (v > Q_MAX) begin
         return Q_MAX[QW-1:0];
      end
      if (v < Q_MIN) begin
         return Q_MIN[QW-1:0];
      end
      return v[QW-1:0];
   endfunction

   function automatic logic signed [SAT_W-1:0] widen_q(input logic signed [QW-1:0] v);
      return $signed({{(SAT_W-QW){v[QW-1]}}, v});
   endfunction

   function automatic logic signed [SAT_W-1:0] widen_m(input logic [RMAG_W-1:0] v);
      return $signed(SAT_W'(v));
   endfunction

   logic [PROD_W-1:0]        prodr_ff, prodr_in, prodi_ff, prodi_in;
   logic signed [QW-1:0]     origr_ff, origr_in, origi_ff, origi_in;
   logic signed [QW-1:0]     cr_ff, cr_in, ci_ff, ci_in;
   logic signed [QW-1:0]     zr_ff, zr_in, zi_ff, zi_in;
   logic [M-1:0]             mzr_ff, mzr_in, mzi_ff, mzi_in;
   logic                     neg_ff, neg_in;
   logic [ACC_W-1:0]         pp_ff [3];
   logic [ACC_W-1:0]         pp_in [3];
   logic [ACC_W-1:0]         acc_ff [3];
   logic [ACC_W-1:0]         acc_in [3];
   logic [RMAG_W-1:0]        rmag_ff [3];
   logic [RMAG_W-1:0]        rmag_in [3];
   logic [ITER_W-1:0]        count_ff, count_in;
   logic [ITER_W-1:0]        esc_ff, esc_in;
   logic [MAG_OUT_W-1:0]     mag_out_ff, mag_out_in;

   logic [SUM_W-1:0]         mag_sum;
   logic [SUM_W-1:0]         mag_q24;

   assign mag_sum         = SUM_W'(rmag_ff[0]) + SUM_W'(rmag_ff[1]);
   assign mag_q24         = mag_sum >> Q24_SHR;
   assign status.finished = (count_ff >= cfg.max_iterations) || (mag_sum >= FOUR);

   assign rsp_escape_count   = esc_ff;
   assign rsp_exit_magnitude = mag_out_ff;

   // Pixel coordinate: index times step plus the origin, origin and sum clamped to the Q8 range.
   always_comb begin
      prodr_in = prodr_ff;
      prodi_in = prodi_ff;
      origr_in = origr_ff;
      origi_in = origi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      if (cmd.load_pixel) begin
         prodr_in = PROD_W'(clamp_index(req_pixel_col)) * PROD_W'(cfg.pixel_step);
         prodi_in = PROD_W'(clamp_index(req_pixel_row)) * PROD_W'(cfg.pixel_step);
         origr_in = sat_q($signed({{(SAT_W-ORIGIN_W){cfg.origin_real[ORIGIN_W-1]}},
                                   cfg.origin_real}));
         origi_in = sat_q($signed({{(SAT_W-ORIGIN_W){cfg.origin_imag[ORIGIN_W-1]}},
                                   cfg.origin_imag}));
      end
      if (cmd.form_c) begin
         cr_in = sat_q($signed(SAT_W'(prodr_ff)) + widen_q(origr_ff));
         ci_in = sat_q($signed(SAT_W'(prodi_ff)) + widen_q(origi_ff));
      end
   end

   // Magnitudes and product sign of the current z feed the multiplier lanes.
   always_comb begin
      logic signed [M-1:0] zr_x;
      logic signed [M-1:0] zi_x;
      zr_x   = $signed({{(M-QW){zr_ff[QW-1]}}, zr_ff});
      zi_x   = $signed({{(M-QW){zi_ff[QW-1]}}, zi_ff});
      mzr_in = mzr_ff;
      mzi_in = mzi_ff;
      neg_in = neg_ff;
      if (cmd.take_abs) begin
         mzr_in = zr_ff[QW-1] ? $unsigned(-zr_x) : $unsigned(zr_x);
         mzi_in = zi_ff[QW-1] ? $unsigned(-zi_x) : $unsigned(zi_x);
         neg_in = zr_ff[QW-1] ^ zi_ff[QW-1];
      end
   end

   // Lane 0 squares zr, lane 1 squares zi, lane 2 forms 2*zr*zi, all on magnitudes.
   // Each lane multiplies one piece pair, split at bit 32, per phase and accumulates it.
   always_comb begin
      logic [M-1:0]       opa [3];
      logic [M-1:0]       opb [3];
      logic [OPW-1:0]     a_piece;
      logic [OPW-1:0]     b_piece;
      logic [2*OPW-1:0]   piece_prod;
      logic [6:0]         shamt;
      logic [ACC_W:0]     rsum;
      logic [CMP_W-1:0]   rext;
      opa[0] = mzr_ff;
      opb[0] = mzr_ff;
      opa[1] = mzi_ff;
      opb[1] = mzi_ff;
      opa[2] = {mzr_ff[M-2:0], 1'b0};
      opb[2] = mzi_ff;
      shamt  = {cmd.mul_phase[1] & cmd.mul_phase[0],
                cmd.mul_phase[1] ^ cmd.mul_phase[0], 5'b0};
      for (int l = 0; l < 3; l++) begin
         a_piece = cmd.mul_phase[1] ? OPW'(opa[l][M-1:32]) : OPW'(opa[l][31:0]);
         b_piece = cmd.mul_phase[0] ? OPW'(opb[l][M-1:32]) : OPW'(opb[l][31:0]);
         piece_prod = a_piece * b_piece;
         pp_in[l]   = cmd.mul_en ? (ACC_W'(piece_prod) << shamt) : pp_ff[l];
         if (cmd.acc_clear) begin
            acc_in[l] = '0;
         end else if (cmd.acc_add) begin
            acc_in[l] = acc_ff[l] + pp_ff[l];
         end else begin
            acc_in[l] = acc_ff[l];
         end
         // Round half away from zero on the magnitude, then cap at 2^62.
         rsum = {1'b0, acc_ff[l]} + HALF;
         rext = CMP_W'(rsum[ACC_W:FRAC_BITS]);
         if (cmd.round) begin
            rmag_in[l] = (rext > MAG_CAP) ? MAG_CAP[RMAG_W-1:0] : rext[RMAG_W-1:0];
         end else begin
            rmag_in[l] = rmag_ff[l];
         end
      end
   end

   // z update, iteration count and result capture.
   always_comb begin
      logic signed [SAT_W-1:0] prod_s;
      prod_s     = neg_ff ? -widen_m(rmag_ff[2]) : widen_m(rmag_ff[2]);
      zr_in      = zr_ff;
      zi_in      = zi_ff;
      count_in   = count_ff;
      esc_in     = esc_ff;
      mag_out_in = mag_out_ff;
      if (cmd.form_c) begin
         zr_in    = '0;
         zi_in    = '0;
         count_in = '0;
      end
      if (cmd.advance) begin
         zr_in    = sat_q(widen_m(rmag_ff[0]) - widen_m(rmag_ff[1]) + widen_q(cr_ff));
         zi_in    = sat_q(prod_s + widen_q(ci_ff));
         count_in = count_ff + ITER_W'(1);
      end
      if (cmd.load_result) begin
         esc_in     = count_ff;
         mag_out_in = (|mag_q24[SUM_W-1:MAG_OUT_W]) ? '1 : mag_q24[MAG_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prodr_ff   <= prodr_in;
      prodi_ff   <= prodi_in;
      origr_ff   <= origr_in;
      origi_ff   <= origi_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      mzr_ff     <= mzr_in;
      mzi_ff     <= mzi_in;
      neg_ff     <= neg_in;
      pp_ff      <= pp_in;
      acc_ff     <= acc_in;
      rmag_ff    <= rmag_in;
      count_ff   <= count_in;
      esc_ff     <= esc_in;
      mag_out_ff <= mag_out_in;
   end

endmodule

>>> src/mandelbrot_escape_iterator_core.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_ready | req_pixel_col, req_pixel_row
// rsp     | out       | rsp_valid, rsp_ready | rsp_escape_count, rsp_exit_magnitude
// csr     | in        | csr_valid, csr_ready | csr_index, csr_data
//
// A pixel is taken in the idle state and forms c; each pass over z then takes the
// magnitudes, runs the three multiplier lanes through four partial products each,
// rounds, and decides between an update of z and loading the result.
// Reset is synchronous and restores the controller and csr registers to their
// defaults; the datapath registers have no reset.
// A finished result that is not yet taken holds the core in its last step; the csr
// port is always ready.
module mandelbrot_escape_iterator_core import mei_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COL_W-1:0]       req_pixel_col,
   input  logic [COL_W-1:0]       req_pixel_row,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ITER_W-1:0]      rsp_escape_count,
   output logic [MAG_OUT_W-1:0]   rsp_exit_magnitude,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   mei_cfg_type    cfg;
   mei_cmd_type    cmd;
   mei_status_type status;

   mei_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mei_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .req_pixel_col      (req_pixel_col),
      .req_pixel_row      (req_pixel_row),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .rsp_escape_count   (rsp_escape_count),
      .rsp_exit_magnitude (rsp_exit_magnitude)
   );

endmodule
